// ===== hw/rtl/rgbc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the rgb clamp with desaturation block
// no dependencies

package rgbc_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CH_W      = 18;
    localparam int OUT_W     = 13;
    localparam int PROD_W    = 31;
    localparam int SUM_W     = 33;
    localparam int LUMA_W    = 21;
    localparam int DEN_W     = 19;
    localparam int REM_W     = 20;
    localparam int Q_W       = FRAC_BITS;
    localparam int SAT_W     = FRAC_BITS + 1;
    localparam int DIFF_W    = 22;
    localparam int SPROD_W   = DIFF_W + SAT_W + 1;

    localparam logic [SAT_W-1:0] ONE_VAL = SAT_W'(1) << FRAC_BITS;

    // luma weights are q0.12 whatever the channel format
    localparam logic [11:0] W_RED   = 12'd1225;
    localparam logic [11:0] W_GREEN = 12'd2404;
    localparam logic [11:0] W_BLUE  = 12'd467;
    localparam int          W_SHIFT = 12;

    // register stages: input, products, luma, divider setup,
    // one per quotient bit, factor minimum, scale product, output
    localparam int ST_IN    = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_LUMA  = 2;
    localparam int ST_SETUP = 3;
    localparam int ST_DIV0  = 4;
    localparam int ST_MIN   = ST_DIV0 + Q_W;
    localparam int ST_SCALE = ST_MIN + 1;
    localparam int NSTG     = ST_SCALE + 1;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_WHITE,
        MODE_BLACK
    } mode_t;

    typedef struct packed {
        logic [2:0][CH_W-1:0]    ch;
        logic [2:0][PROD_W-1:0]  prod;
        logic [LUMA_W-1:0]       luma;
        mode_t                   mode;
        logic [2:0]              act;
        logic [2:0][REM_W-1:0]   rem;
        logic [2:0][DEN_W-1:0]   den;
        logic [2:0][Q_W-1:0]     quo;
        logic [SAT_W-1:0]        sat;
        logic [2:0][SPROD_W-1:0] sprod;
    } pix_t;

endpackage

// ===== hw/rtl/rgb_clamp_with_desaturation.sv =====
`timescale 1ns / 1ps
// top level of the luma preserving rgb gamut clamp
// depends on rgbc_pkg and rgbc_div_step
//
// usage:
//   input channel: in_valid / in_ready with red_in, green_in, blue_in,
//     signed q5.12 (4096 is 1.0), one item per pixel
//   output channel: out_valid / out_ready with red_out, green_out,
//     blue_out (unsigned 0..4096) and was_adjusted
//   throughput: one item per cycle when not stalled, pixels are independent
//   the pipeline is input register, luma products, luma sum, divider
//     setup, twelve restoring divider stages (one quotient bit each,
//     three lanes), factor minimum, scale product and final clamp
//   stall: when out_valid is high and out_ready low the whole pipeline
//     holds; in_ready is low exactly then, nothing is lost or repeated
//   reset: rst_n clears all valid bits at once; in_ready is high in the
//     first cycle after reset, payload registers are left as they are
//   luma above one gives white, below zero gives black; otherwise the
//     smallest desaturation factor pulls channels toward luma

module rgb_clamp_with_desaturation
    import rgbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CH_W-1:0]  red_in,
    input  logic signed [CH_W-1:0]  green_in,
    input  logic signed [CH_W-1:0]  blue_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        red_out,
    output logic [OUT_W-1:0]        green_out,
    output logic [OUT_W-1:0]        blue_out,
    output logic                    was_adjusted
);

    // pipeline registers, one slot per stage, valid bit alongside
    pix_t            stg_reg  [NSTG];
    pix_t            stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    logic [OUT_W-1:0] res_reg  [3];
    logic [OUT_W-1:0] res_next [3];
    logic             adj_reg;
    logic             adj_next;
    logic             out_vld_reg;

    logic [REM_W-1:0] div_rem [Q_W][3];
    logic [Q_W-1:0]   div_quo [Q_W][3];

    // the whole pipeline moves unless the result waits on the receiver
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // divider steps, one stage per quotient bit
    genvar gk, gl;
    generate
        for (gk = 0; gk < Q_W; gk++)
        begin : g_div
            for (gl = 0; gl < 3; gl++)
            begin : g_lane
                rgbc_div_step u_step (
                    .rem     (stg_reg[ST_SETUP + gk].rem[gl]),
                    .den     (stg_reg[ST_SETUP + gk].den[gl]),
                    .quo     (stg_reg[ST_SETUP + gk].quo[gl]),
                    .rem_nxt (div_rem[gk][gl]),
                    .quo_nxt (div_quo[gk][gl])
                );
            end
        end
    endgenerate

    logic [11:0]              wts [3];
    logic signed [SUM_W-1:0]  sum;
    logic signed [LUMA_W-1:0] lum;
    logic signed [LUMA_W-1:0] cs;
    logic signed [LUMA_W-1:0] lsub;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SPROD_W-1:0] sp;
    logic signed [SPROD_W-FRAC_BITS-1:0] off;
    logic signed [SPROD_W-FRAC_BITS:0]   val;
    logic [SAT_W-1:0]         smin;

    assign wts[0] = W_RED;
    assign wts[1] = W_GREEN;
    assign wts[2] = W_BLUE;

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            stg_next[k] = (k == 0) ? stg_reg[0] : stg_reg[k-1];
        end

        // input capture
        stg_next[ST_IN].ch[0] = red_in;
        stg_next[ST_IN].ch[1] = green_in;
        stg_next[ST_IN].ch[2] = blue_in;

        // weighted products
        for (int n = 0; n < 3; n++)
        begin
            stg_next[ST_PROD].prod[n] = PROD_W'($signed(stg_reg[ST_IN].ch[n])
                                        * $signed({1'b0, wts[n]}));
        end

        // luma sum, floor by arithmetic bit select
        sum = SUM_W'($signed(stg_reg[ST_PROD].prod[0]))
            + SUM_W'($signed(stg_reg[ST_PROD].prod[1]))
            + SUM_W'($signed(stg_reg[ST_PROD].prod[2]));
        stg_next[ST_LUMA].luma = sum[SUM_W-1:W_SHIFT];
        lum = $signed(sum[SUM_W-1:W_SHIFT]);
        if (lum > $signed({{(LUMA_W-SAT_W){1'b0}}, ONE_VAL}))
            stg_next[ST_LUMA].mode = MODE_WHITE;
        else if (lum < 0)
            stg_next[ST_LUMA].mode = MODE_BLACK;
        else
            stg_next[ST_LUMA].mode = MODE_NORMAL;

        // divider setup: numerator as first remainder, divisor per lane
        lsub = $signed(stg_reg[ST_LUMA].luma);
        for (int n = 0; n < 3; n++)
        begin
            cs = LUMA_W'($signed(stg_reg[ST_LUMA].ch[n]));
            stg_next[ST_SETUP].quo[n] = '0;
            stg_next[ST_SETUP].act[n] = 1'b0;
            stg_next[ST_SETUP].rem[n] = '0;
            stg_next[ST_SETUP].den[n] = DEN_W'(1);
            if (cs > $signed({{(LUMA_W-SAT_W){1'b0}}, ONE_VAL}))
            begin
                stg_next[ST_SETUP].act[n] = 1'b1;
                stg_next[ST_SETUP].rem[n] = REM_W'(ONE_VAL - lsub[SAT_W-1:0]);
                stg_next[ST_SETUP].den[n] = DEN_W'(cs - lsub);
            end
            else if (cs < 0)
            begin
                stg_next[ST_SETUP].act[n] = 1'b1;
                stg_next[ST_SETUP].rem[n] = REM_W'(lsub[SAT_W-1:0]);
                stg_next[ST_SETUP].den[n] = DEN_W'(lsub - cs);
            end
            // white and black pixels mark no lane active, so their quotients are ignored
            if (stg_reg[ST_LUMA].mode != MODE_NORMAL)
                stg_next[ST_SETUP].act[n] = 1'b0;
        end

        for (int k = 0; k < Q_W; k++)
        begin
            for (int n = 0; n < 3; n++)
            begin
                stg_next[ST_DIV0 + k].rem[n] = div_rem[k][n];
                stg_next[ST_DIV0 + k].quo[n] = div_quo[k][n];
            end
        end

        // smallest factor over the lanes that were out of range
        smin = ONE_VAL;
        for (int n = 0; n < 3; n++)
        begin
            if (stg_reg[ST_MIN-1].act[n] && ({1'b0, stg_reg[ST_MIN-1].quo[n]} < smin))
                smin = {1'b0, stg_reg[ST_MIN-1].quo[n]};
        end
        stg_next[ST_MIN].sat = smin;

        // offset from luma times factor
        for (int n = 0; n < 3; n++)
        begin
            diff = DIFF_W'($signed(stg_reg[ST_MIN].ch[n]))
                 - DIFF_W'($signed(stg_reg[ST_MIN].luma));
            stg_next[ST_SCALE].sprod[n] = SPROD_W'(diff
                                          * $signed({1'b0, stg_reg[ST_MIN].sat}));
        end

        // final clamp
        adj_next = 1'b1;
        for (int n = 0; n < 3; n++)
        begin
            sp  = $signed(stg_reg[ST_SCALE].sprod[n]);
            off = sp[SPROD_W-1:FRAC_BITS];
            val = (SPROD_W-FRAC_BITS+1)'($signed(stg_reg[ST_SCALE].luma)) + off;
            case (stg_reg[ST_SCALE].mode)
                MODE_WHITE: res_next[n] = OUT_W'(ONE_VAL);
                MODE_BLACK: res_next[n] = '0;
                default:
                begin
                    if (val < 0)
                        res_next[n] = '0;
                    else if (val > $signed({{(SPROD_W-FRAC_BITS+1-SAT_W){1'b0}}, ONE_VAL}))
                        res_next[n] = OUT_W'(ONE_VAL);
                    else
                        res_next[n] = val[OUT_W-1:0];
                end
            endcase
        end
        if (stg_reg[ST_SCALE].mode == MODE_NORMAL && stg_reg[ST_SCALE].sat == ONE_VAL)
            adj_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NSTG-2:0], in_valid};
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
            for (int n = 0; n < 3; n++)
            begin
                res_reg[n] <= res_next[n];
            end
            adj_reg <= adj_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign red_out      = res_reg[0];
    assign green_out    = res_reg[1];
    assign blue_out     = res_reg[2];
    assign was_adjusted = adj_reg;

`ifndef NO_ASSERTIONS
    // results never leave the unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out <= OUT_W'(ONE_VAL)) && (green_out <= OUT_W'(ONE_VAL))
                      && (blue_out <= OUT_W'(ONE_VAL)))
        else $error("result channel above one");

    // a stalled pipeline keeps its first stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !adv |=> vld_reg[0] && $stable(stg_reg[0].ch))
        else $error("pipeline moved during stall");

    // saturated luma always flags the pixel
    a_adj: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-1] && stg_reg[ST_SCALE].mode != MODE_NORMAL |-> adj_next)
        else $error("saturated luma not flagged");
`endif

endmodule

// ===== hw/rtl/rgbc_div_step.sv =====
`timescale 1ns / 1ps
// one restoring division step: shift, compare, subtract, one quotient bit
// depends on rgbc_pkg

module rgbc_div_step
    import rgbc_pkg::*;
(
    input  logic [REM_W-1:0] rem,
    input  logic [DEN_W-1:0] den,
    input  logic [Q_W-1:0]   quo,
    output logic [REM_W-1:0] rem_nxt,
    output logic [Q_W-1:0]   quo_nxt
);

    logic [REM_W-1:0] shifted;
    logic             take;

    always_comb
    begin
        // remainder stays below the divisor, so the shift never overflows
        shifted = {rem[REM_W-2:0], 1'b0};
        take    = shifted >= {1'b0, den};
        rem_nxt = take ? shifted - {1'b0, den} : shifted;
        quo_nxt = {quo[Q_W-2:0], take};
    end

endmodule

// ===== verif/rgb_clamp_with_desaturation_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the luma preserving rgb gamut clamp
// depends on rgbc_pkg and the rgb_clamp_with_desaturation rtl

module rgb_clamp_with_desaturation_test;
    import rgbc_pkg::*;

    localparam int N_RANDOM    = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int UNIT        = 4096;

    typedef struct {
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] g;
        logic [OUT_W-1:0] b;
        logic             adj;
    } clamped_pix_t;

    // directed row: inputs plus an optional typed-in result
    typedef struct {
        int           r;
        int           g;
        int           b;
        bit           typed;
        clamped_pix_t res;
    } pix_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CH_W-1:0] red_in;
    logic signed [CH_W-1:0] green_in;
    logic signed [CH_W-1:0] blue_in;
    logic out_valid;
    logic out_ready;
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic was_adjusted;

    clamped_pix_t pending_pix[$];
    int           fail_count;
    int           cycle_count;

    rgb_clamp_with_desaturation u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .was_adjusted (was_adjusted)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // floor division by 2^12 that stays correct for negative sums
    function automatic longint floor_frac(longint x);
        if (x >= 0)
        begin
            return x >>> FRAC_BITS;
        end
        return -((-x + UNIT - 1) >>> FRAC_BITS);
    endfunction

    // predicted clamp of one pixel
    function automatic clamped_pix_t clamp_pixel(logic signed [CH_W-1:0] r,
                                                 logic signed [CH_W-1:0] g,
                                                 logic signed [CH_W-1:0] b);
        longint       c[3];
        longint       luma;
        longint       fac;
        longint       q;
        longint       v[3];
        clamped_pix_t p;
        c[0] = r;
        c[1] = g;
        c[2] = b;
        luma = floor_frac(c[0] * 1225 + c[1] * 2404 + c[2] * 467);
        p.adj = 1'b1;
        if (luma > UNIT)
        begin
            p.r = OUT_W'(UNIT);
            p.g = OUT_W'(UNIT);
            p.b = OUT_W'(UNIT);
            return p;
        end
        if (luma < 0)
        begin
            p.r = '0;
            p.g = '0;
            p.b = '0;
            return p;
        end
        fac = UNIT;
        for (int n = 0; n < 3; n++)
        begin
            if (c[n] > UNIT)
            begin
                q = ((UNIT - luma) << FRAC_BITS) / (c[n] - luma);
                if (q < fac) fac = q;
            end
            else if (c[n] < 0)
            begin
                q = (luma << FRAC_BITS) / (luma - c[n]);
                if (q < fac) fac = q;
            end
        end
        for (int n = 0; n < 3; n++)
        begin
            if (fac == UNIT)
            begin
                v[n] = c[n];
            end
            else
            begin
                v[n] = luma + floor_frac((c[n] - luma) * fac);
                if (v[n] < 0) v[n] = 0;
                if (v[n] > UNIT) v[n] = UNIT;
            end
        end
        p.r = OUT_W'(v[0]);
        p.g = OUT_W'(v[1]);
        p.b = OUT_W'(v[2]);
        p.adj = (fac != UNIT);
        return p;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // most channels near the unit range so desaturation is exercised often
    function automatic int rand_chan();
        case ($urandom_range(0, 5))
            0: return $signed(18'($urandom()));
            1: return $urandom_range(0, UNIT);
            2: return $urandom_range(0, 3 * UNIT) - UNIT;
            default: return $urandom_range(0, 2 * UNIT + 1000) - 1000;
        endcase
    endfunction

    // push one item and wait for its acceptance; expectation is queued
    // at the accept edge so the checker never sees a result first
    task automatic send_pixel(int r, int g, int b, bit typed, clamped_pix_t res);
        int gap;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= CH_W'(r);
        green_in <= CH_W'(g);
        blue_in  <= CH_W'(b);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (typed) pending_pix.push_back(res);
        else pending_pix.push_back(clamp_pixel(CH_W'(r), CH_W'(g), CH_W'(b)));
    endtask

    // output side: random stalls, stretches of steady ready
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = idle_len();
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        clamped_pix_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pix.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                e = pending_pix.pop_front();
                if (red_out !== e.r)
                begin
                    $error("red_out expected %0d actual %0d", e.r, red_out);
                    fail_count++;
                end
                if (green_out !== e.g)
                begin
                    $error("green_out expected %0d actual %0d", e.g, green_out);
                    fail_count++;
                end
                if (blue_out !== e.b)
                begin
                    $error("blue_out expected %0d actual %0d", e.b, blue_out);
                    fail_count++;
                end
                if (was_adjusted !== e.adj)
                begin
                    $error("was_adjusted expected %0d actual %0d", e.adj, was_adjusted);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        pix_row_t     rows[$];
        clamped_pix_t none;
        int           wait_cnt;
        none = '{r: '0, g: '0, b: '0, adj: 1'b0};
        fail_count  = 0;
        cycle_count = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        red_in   = '0;
        green_in = '0;
        blue_in  = '0;

        // in range, extremes, white, black, luma exactly one, desaturation
        rows.push_back('{0, 0, 0, 1, '{0, 0, 0, 0}});
        rows.push_back('{UNIT, UNIT, UNIT, 1, '{UNIT, UNIT, UNIT, 0}});
        rows.push_back('{UNIT, 0, 0, 1, '{UNIT, 0, 0, 0}});
        rows.push_back('{0, UNIT, 2048, 1, '{0, UNIT, 2048, 0}});
        rows.push_back('{131071, 131071, 131071, 1, '{UNIT, UNIT, UNIT, 1}});
        rows.push_back('{-131072, -131072, -131072, 1, '{0, 0, 0, 1}});
        rows.push_back('{131071, -131072, 0, 1, '{0, 0, 0, 1}});
        rows.push_back('{-131072, 131071, -131072, 1, '{UNIT, UNIT, UNIT, 1}});
        rows.push_back('{-131072, 0, 131071, 0, none});
        rows.push_back('{UNIT + 1, UNIT, UNIT, 1, '{UNIT, UNIT, UNIT, 1}});
        rows.push_back('{-1, 0, 0, 1, '{0, 0, 0, 1}});
        rows.push_back('{-1, 100, 100, 0, none});
        rows.push_back('{8000, 1000, 500, 0, none});
        rows.push_back('{8000, 3000, -2000, 0, none});
        rows.push_back('{-3000, 4000, 4000, 0, none});
        rows.push_back('{2000, 6000, -4000, 0, none});
        rows.push_back('{2048, 2048, 20000, 0, none});
        rows.push_back('{131071, 0, 0, 0, none});
        rows.push_back('{0, 0, -131072, 0, none});
        rows.push_back('{UNIT + 500, UNIT - 500, 4096 + 3, 0, none});

        repeat (4) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].typed, rows[i].res);

        for (int i = 0; i < N_RANDOM; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, none);

        in_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < DRAIN_WAIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
